// ===== hw/rtl/ctd_pkg.sv =====
// shared types, constants and helpers of the convolutional time deinterleaver
// no dependencies
package ctd_pkg;

    localparam int unsigned BRANCHES = 16;
    localparam int unsigned ROW_W = 4;
    localparam int unsigned CFG_LEN_W = 14;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic [CFG_LEN_W-1:0] LEN_RESET = 14'd8192;

    typedef enum logic [0:0] {
        REG_ACTIVE_LENGTH = 1'b0
    } reg_index_t;

    function automatic logic [ROW_W-1:0] bitrev4(input logic [ROW_W-1:0] v);
        logic [ROW_W-1:0] r;
        r = {v[0], v[1], v[2], v[3]};
        return r;
    endfunction

endpackage

// ===== hw/rtl/convolutional_time_deinterleaver.sv =====
// path: a kept input word passes the s1 register, then the m_ output register;
// one word per cycle unless stalled, one store read-modify-write per kept word
// reset: synchronous active-low aresetn, then a clearing sweep of all MAX_LENGTH
// store columns (one column of all 16 rows per cycle) while s_ready stays low
// depends on ctd_pkg, ctd_cfg, ctd_store
module convolutional_time_deinterleaver import ctd_pkg::*; #(
    parameter int unsigned MAX_LENGTH = 8192,
    parameter int unsigned SAMPLE_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_soft_sample,
    input  logic                          s_frame_start,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_out_sample,
    output logic                          m_out_start,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready
);

    localparam int unsigned AW = $clog2(MAX_LENGTH);
    localparam int unsigned LW = $clog2(MAX_LENGTH + 1);

    logic [LW-1:0]                        eff_len;
    logic                                 clearing;
    logic [BRANCHES-1:0][SAMPLE_BITS-1:0] rd_data;
    logic [BRANCHES-1:0][SAMPLE_BITS-1:0] wr_data;

    logic [AW-1:0]          pos_reg,  pos_next;
    logic [ROW_W-1:0]       rrow_reg, rrow_next;
    logic                   s1_valid_reg, s1_valid_next;
    logic [AW-1:0]          s1_addr_reg;
    logic [ROW_W-1:0]       s1_rrow_reg;
    logic [ROW_W-1:0]       s1_wrow_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                   s1_start_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [SAMPLE_BITS-1:0] m_sample_reg;
    logic                   m_start_reg;

    logic            s_fire;
    logic            keep;
    logic            s1_adv;
    logic            pos_zero;
    logic [AW:0]     pos_inc;
    logic            last_pos;
    logic [ROW_W-1:0] wrow;
    logic [SAMPLE_BITS-1:0] res_sample;

    ctd_cfg #(
        .MAX_LENGTH(MAX_LENGTH),
        .LEN_W(LW)
    ) u_cfg (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .eff_len(eff_len)
    );

    ctd_store #(
        .DEPTH(MAX_LENGTH),
        .ADDR_W(AW),
        .LANE_W(SAMPLE_BITS)
    ) u_store (
        .aclk(aclk),
        .aresetn(aresetn),
        .rd_en(keep),
        .rd_addr(pos_reg),
        .rd_data(rd_data),
        .wr_en(s1_adv),
        .wr_addr(s1_addr_reg),
        .wr_data(wr_data),
        .clearing(clearing)
    );

    assign pready   = 1'b1;
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !clearing && (!s1_valid_reg || s1_adv);
    assign s_fire   = s_valid && s_ready;
    assign pos_zero = (pos_reg == '0);
    assign keep     = s_fire && (!pos_zero || s_frame_start);
    assign pos_inc  = {1'b0, pos_reg} + (AW + 1)'(1);
    assign last_pos = (pos_inc >= (AW + 1)'(eff_len));
    assign wrow     = rrow_reg - bitrev4(pos_reg[ROW_W-1:0]);

    always_comb begin
        pos_next  = pos_reg;
        rrow_next = rrow_reg;
        if (keep) begin
            if (last_pos) begin
                pos_next  = '0;
                rrow_next = rrow_reg + ROW_W'(1);
            end else begin
                pos_next = pos_inc[AW-1:0];
            end
        end
    end

    always_comb begin
        wr_data = rd_data;
        wr_data[s1_wrow_reg] = s1_sample_reg;
        if (s1_wrow_reg == s1_rrow_reg) begin
            res_sample = s1_sample_reg;
        end else begin
            res_sample = rd_data[s1_rrow_reg];
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (keep) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            rrow_reg     <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            rrow_reg     <= rrow_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (keep) begin
            s1_addr_reg   <= pos_reg;
            s1_rrow_reg   <= rrow_reg;
            s1_wrow_reg   <= wrow;
            s1_sample_reg <= s_soft_sample;
            s1_start_reg  <= pos_zero;
        end
        if (s1_adv) begin
            m_sample_reg <= res_sample;
            m_start_reg  <= s1_start_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_sample = m_sample_reg;
    assign m_out_start  = m_start_reg;

endmodule

// ===== hw/rtl/ctd_cfg.sv =====
// apb register block: active_length and its clamped effective value
// depends on ctd_pkg
module ctd_cfg import ctd_pkg::*; #(
    parameter int unsigned MAX_LENGTH = 8192,
    parameter int unsigned LEN_W = 14
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic [LEN_W-1:0]      eff_len
);

    logic [CFG_LEN_W-1:0] active_length_reg;
    logic [CFG_LEN_W-1:0] active_length_next;
    logic                 hit;
    logic [31:0]          len32;

    assign hit = (paddr[APB_ADDR_W-1] == REG_ACTIVE_LENGTH);

    always_comb begin
        active_length_next = active_length_reg;
        if (psel && penable && pwrite && hit) begin
            active_length_next = pwdata[CFG_LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_length_reg <= LEN_RESET;
        end else begin
            active_length_reg <= active_length_next;
        end
    end

    assign prdata = hit ? APB_DATA_W'(active_length_reg) : '0;
    assign len32  = 32'(active_length_reg);

    always_comb begin
        if (len32 == 32'd0) begin
            eff_len = LEN_W'(1);
        end else if (len32 > 32'(MAX_LENGTH)) begin
            eff_len = LEN_W'(MAX_LENGTH);
        end else begin
            eff_len = LEN_W'(len32);
        end
    end

endmodule

// ===== hw/rtl/ctd_store.sv =====
// branch store: one word per column holding all 16 rows, clearing sweep after reset,
// registered read with forwarding of a same-cycle write; depends on ctd_pkg
module ctd_store import ctd_pkg::*; #(
    parameter int unsigned DEPTH = 8192,
    parameter int unsigned ADDR_W = 13,
    parameter int unsigned LANE_W = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             rd_en,
    input  logic [ADDR_W-1:0]                rd_addr,
    output logic [BRANCHES-1:0][LANE_W-1:0]  rd_data,
    input  logic                             wr_en,
    input  logic [ADDR_W-1:0]                wr_addr,
    input  logic [BRANCHES-1:0][LANE_W-1:0]  wr_data,
    output logic                             clearing
);

    logic [BRANCHES-1:0][LANE_W-1:0] mem [DEPTH];
    logic [BRANCHES-1:0][LANE_W-1:0] rdata_reg;
    logic [BRANCHES-1:0][LANE_W-1:0] fwd_data_reg;
    logic                            fwd_reg;
    logic                            fwd_next;
    logic                            clearing_reg;
    logic                            clearing_next;
    logic [ADDR_W-1:0]               clr_addr_reg;
    logic [ADDR_W-1:0]               clr_addr_next;
    logic                            mem_we;
    logic [ADDR_W-1:0]               mem_wa;
    logic [BRANCHES-1:0][LANE_W-1:0] mem_wd;

    always_comb begin
        mem_we = clearing_reg || wr_en;
        mem_wa = clearing_reg ? clr_addr_reg : wr_addr;
        mem_wd = clearing_reg ? '0 : wr_data;
    end

    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                clearing_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    assign fwd_next = rd_en ? (wr_en && (wr_addr == rd_addr)) : fwd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            fwd_reg      <= 1'b0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            fwd_reg      <= fwd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            rdata_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data  = fwd_reg ? fwd_data_reg : rdata_reg;
    assign clearing = clearing_reg;

endmodule

// ===== hw/rtl/ctd_checker.sv =====
// port-level checks for the convolutional time deinterleaver, bound to the top level
// depends on ctd_pkg
module ctd_checker import ctd_pkg::*; #(
    parameter int unsigned SAMPLE_BITS = 8
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_out_sample,
    input logic                          m_out_start,
    input logic                          pready
);

    // reset empties the output word
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output word valid right after reset");

    // clearing sweep blocks input after reset
    assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input ready right after reset");

    // stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_sample) && $stable(m_out_start))
        else $error("stalled output word changed");

    assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind convolutional_time_deinterleaver ctd_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_ctd_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_out_sample(m_out_sample),
    .m_out_start(m_out_start),
    .pready(pready)
);

// ===== verif/ctd_deint_checker.sv =====
// checker for the convolutional time deinterleaver: watches both word channels
// and the register port, predicts each output word and compares it field by field
// depends on ctd_pkg
`timescale 1ns / 1ps

module ctd_deint_checker import ctd_pkg::*; #(
    parameter int unsigned MAX_LENGTH = 8192,
    parameter int unsigned SAMPLE_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_soft_sample,
    input  logic                          s_frame_start,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic signed [SAMPLE_BITS-1:0] m_out_sample,
    input  logic                          m_out_start,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output int                            fail_count,
    output int                            pending_words
);

    localparam int MAX_REPORTS = 10;
    // row offset per column mod 16, entry c at bits 4c+3:4c
    localparam logic [63:0] ROW_OFFSETS = {
        4'd15, 4'd7, 4'd11, 4'd3, 4'd13, 4'd5, 4'd9, 4'd1,
        4'd14, 4'd6, 4'd10, 4'd2, 4'd12, 4'd4, 4'd8, 4'd0
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          start;
    } deint_word_t;

    logic [SAMPLE_BITS-1:0] row_mem [BRANCHES][MAX_LENGTH];
    logic [ROW_W-1:0]       read_row;
    int unsigned            vec_pos;
    logic [CFG_LEN_W-1:0]   frame_len;
    deint_word_t            deinterleaved_q [$];

    function automatic int unsigned frame_span(input logic [CFG_LEN_W-1:0] len);
        if (len == 0)
            return 1;
        if (len > MAX_LENGTH)
            return MAX_LENGTH;
        return 32'(len);
    endfunction

    function automatic void deinterleave_word(input logic [SAMPLE_BITS-1:0] sample,
                                              input logic start);
        int unsigned col;
        logic [ROW_W-1:0] write_row;
        deint_word_t w;
        // resync: a word without start flag at position 0 is dropped
        if (vec_pos == 0 && !start)
            return;
        col = vec_pos % MAX_LENGTH;
        write_row = read_row - ROW_OFFSETS[(col % BRANCHES) * ROW_W +: ROW_W];
        row_mem[write_row][col] = sample;
        w.sample = row_mem[read_row][col];
        w.start = (vec_pos == 0);
        deinterleaved_q.push_back(w);
        if (vec_pos + 1 >= frame_span(frame_len)) begin
            vec_pos = 0;
            read_row = read_row + 1'b1;
        end else begin
            vec_pos = vec_pos + 1;
        end
    endfunction

    always @(posedge aclk) begin : watch
        deint_word_t want;
        if (!aresetn) begin
            foreach (row_mem[r, c])
                row_mem[r][c] = '0;
            read_row = '0;
            vec_pos = 0;
            frame_len = LEN_RESET;
            deinterleaved_q.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (deinterleaved_q.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: unexpected word, sample %0d start %0b",
                                 $realtime, m_out_sample, m_out_start);
                    fail_count++;
                end else begin
                    want = deinterleaved_q.pop_front();
                    if (m_out_sample !== want.sample || m_out_start !== want.start) begin
                        if (fail_count < MAX_REPORTS)
                            $display("%0t: mismatch, expected sample %0d start %0b, got %0d %0b",
                                     $realtime, want.sample, want.start,
                                     m_out_sample, m_out_start);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                deinterleave_word(s_soft_sample, s_frame_start);
            if (psel && penable && pwrite && pready
                    && paddr == APB_ADDR_W'(4 * REG_ACTIVE_LENGTH))
                frame_len = pwdata[CFG_LEN_W-1:0];
        end
        pending_words = deinterleaved_q.size();
    end

endmodule

// ===== verif/tb_convolutional_time_deinterleaver.sv =====
// testbench top for the convolutional time deinterleaver: directed and random
// word streams over several frame lengths, random stalls on both sides
// depends on ctd_pkg, the deinterleaver rtl and ctd_deint_checker
`timescale 1ns / 1ps

module tb_convolutional_time_deinterleaver;
    import ctd_pkg::*;

    localparam int unsigned MAX_LENGTH = 8192;
    localparam int unsigned SAMPLE_BITS = 8;
    localparam int PIPE_SETTLE = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int WORD_TARGET = 1100;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_soft_sample;
    logic                          s_frame_start;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [SAMPLE_BITS-1:0] m_out_sample;
    logic                          m_out_start;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [APB_ADDR_W-1:0]         paddr;
    logic [APB_DATA_W-1:0]         pwdata;
    logic [APB_DATA_W-1:0]         prdata;
    logic                          pready;
    int                            fail_count;
    int                            pending_words;

    logic tx_steady = 1'b0;
    logic rx_steady = 1'b0;
    logic hold_armed = 1'b0;

    convolutional_time_deinterleaver #(
        .MAX_LENGTH(MAX_LENGTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (.*);

    ctd_deint_checker #(
        .MAX_LENGTH(MAX_LENGTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) deint_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic send_word(input logic [SAMPLE_BITS-1:0] sample, input logic start);
        int gap;
        int pick;
        gap = 0;
        if (!tx_steady) begin
            pick = $urandom_range(0, 99);
            if (pick >= 93)
                gap = $urandom_range(8, 30);
            else if (pick >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_soft_sample <= sample;
        s_frame_start <= start;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_words != 0);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    task automatic write_length(input logic [CFG_LEN_W-1:0] len);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(4 * REG_ACTIVE_LENGTH);
        pwdata <= APB_DATA_W'(len);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // receiver side
    initial begin : sink
        int pick;
        logic hold_taken;
        hold_taken = 1'b0;
        m_ready = 1'b0;
        forever begin
            if (hold_armed && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (rx_steady) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    m_ready <= 1'b1;
                    @(posedge aclk);
                end else if (pick < 95) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        int len;
        int vectors;
        int pick;
        int words_sent;
        logic first_phase;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_soft_sample = '0;
        s_frame_start = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        words_sent = 0;
        first_phase = 1'b1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // resync drops, then the start of a vector at reset length with start flags mid-vector
        send_word(8'h80, 1'b0);
        send_word(8'h7f, 1'b0);
        send_word(8'h80, 1'b1);
        send_word(8'h7f, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b1);
        send_word(8'h01, 1'b0);
        send_word(8'h55, 1'b0);
        send_word(8'haa, 1'b1);
        send_word(8'h2a, 1'b0);
        settle();
        // shrink below the current position
        write_length(14'd3);
        send_word(8'h40, 1'b0);
        send_word(8'h11, 1'b0);
        settle();
        // zero length behaves as one
        write_length(14'd0);
        send_word(8'h7f, 1'b1);
        send_word(8'h80, 1'b1);
        send_word(8'h33, 1'b0);
        send_word(8'hc3, 1'b1);
        settle();
        // above the maximum, all register bits set
        write_length(14'h3fff);
        send_word(8'h5a, 1'b1);
        send_word(8'ha5, 1'b0);
        send_word(8'h80, 1'b1);
        send_word(8'h7f, 1'b0);
        settle();
        write_length(14'd2);
        send_word(8'h0f, 1'b1);
        settle();

        while (words_sent < WORD_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(1, 20);
            else if (pick < 90)
                len = $urandom_range(21, 120);
            else if (pick < 95)
                len = 16;
            else
                len = 1;
            vectors = (len <= 20) ? $urandom_range(17, 30) : $urandom_range(3, 6);
            if (words_sent + len * vectors > WORD_TARGET)
                vectors = (WORD_TARGET - words_sent + len - 1) / len;
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            write_length(len[CFG_LEN_W-1:0]);
            if (first_phase) begin
                first_phase = 1'b0;
                tx_steady = 1'b1;
                hold_armed = 1'b1;
            end
            repeat (vectors) begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 3))
                        send_word(SAMPLE_BITS'($urandom_range(0, 255)), 1'b0);
                send_word(SAMPLE_BITS'($urandom_range(0, 255)), 1'b1);
                for (int p = 1; p < len; p++)
                    send_word(SAMPLE_BITS'($urandom_range(0, 255)),
                              $urandom_range(0, 4) == 0);
            end
            words_sent += len * vectors;
            settle();
        end

        if (fail_count == 0 && pending_words == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
